@@ rtl/kcrf_pkg.sv @@
// Package for the k-mer count read filter: register indexes, filter modes,
// widths of the delay line and saturation limits. No dependencies.
package kcrf_pkg;

  localparam int MAX_KMER     = 32;
  localparam int LINE_AW      = $clog2(MAX_KMER);
  localparam int FILL_W       = LINE_AW + 1;
  localparam int FRAC_W       = 17;
  localparam int CNT_W        = 32;
  localparam int SAT_W        = 16;

  localparam logic [SAT_W-1:0] MAX_READ_LEN = 16'hFFFF;
  localparam logic [SAT_W-1:0] SAT16        = 16'hFFFF;
  localparam logic [7:0]       N_CHAR       = 8'd78;

  // Register indexes on the configuration port.
  localparam logic [2:0] CFG_MODE     = 3'd0;
  localparam logic [2:0] CFG_KLEN     = 3'd1;
  localparam logic [2:0] CFG_MIN_CNT  = 3'd2;
  localparam logic [2:0] CFG_MAX_CNT  = 3'd3;
  localparam logic [2:0] CFG_MIN_FRAC = 3'd4;
  localparam logic [2:0] CFG_MAX_FRAC = 3'd5;

  // Filter modes.
  localparam logic [1:0] MODE_COUNT = 2'd0;
  localparam logic [1:0] MODE_FRAC  = 2'd1;
  localparam logic [1:0] MODE_TRIM  = 2'd2;
  localparam logic [1:0] MODE_MASK  = 2'd3;

  typedef logic [7:0]         base_t;
  typedef logic [LINE_AW-1:0] line_addr_t;

endpackage

@@ rtl/kcrf_line_ram.sv @@
// Delay-line storage for read bases: one write port, one read port with
// a registered read that holds its data until the next read. Uses kcrf_pkg.
module kcrf_line_ram
  import kcrf_pkg::*;
(
  input  logic       clk,
  input  logic       wr_en,
  input  line_addr_t wr_addr,
  input  base_t      wr_data,
  input  logic       rd_en,
  input  line_addr_t rd_addr,
  output base_t      rd_data
);

  base_t mem [MAX_KMER];
  base_t rd_data_r;

  // Read-first: a read and a write of the same entry return the old base.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/kmer_count_read_filter_unit.sv @@
// Top level of the k-mer count read filter, trimmer and masker.
// Depends on kcrf_pkg and kcrf_line_ram.
//
// Usage: one read base per input item on in_* together with the database
// count of the k-mer ending at that base; in_tlast marks the final base.
// Results leave on out_*, out_tlast marks the last result of a read.
// The user must write registers on cfg_* while the block is idle (not enforced).
// Throughput: one base per cycle within a read, in mask mode only while the
// receiver keeps up. In mask mode each base that leaves the (k-1)-deep delay
// line is read back from the line memory and passes the stage and the output
// register to out_tvalid. At the end of a read the mask mode drains the
// remaining entries one per cycle while the receiver keeps up (the single
// read port of the line memory sets this), and no base is taken meanwhile.
// The other modes go from the last base through ST_CALC (fraction products),
// ST_VERDICT (compare into the stage) and the output register. Input pauses in
// both states; the next read may start once the verdict is in the stage.
// Reset restores the register defaults and empties the delay line; the
// read state also clears itself after every last base.
// When the receiver stalls, results wait in the output register and one
// stage behind it; in mask mode the delay line then stops popping and input stalls as
// soon as a base would have to leave the line.
module kmer_count_read_filter_unit
  import kcrf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // base[7:0], kmer_count[39:8]
  input  logic        in_tlast,   // last_base
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // out_base[7:0], keep[8], trim_length[24:9],
                                  // kmers_found[40:25], zero[47:41]
  output logic        out_tuser,  // has_base
  output logic        out_tlast   // end_of_read
);

  typedef enum logic [3:0] {
    ST_RUN     = 4'b0001,
    ST_FLUSH   = 4'b0010,
    ST_CALC    = 4'b0100,
    ST_VERDICT = 4'b1000
  } state_t;

  // Configuration registers.
  logic [1:0]        mode_r;
  logic [5:0]        klen_r;
  logic [CNT_W-1:0]  min_cnt_r;
  logic [CNT_W-1:0]  max_cnt_r;
  logic [FRAC_W-1:0] min_frac_r;
  logic [FRAC_W-1:0] max_frac_r;

  // Read state.
  state_t           state_r;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] mask_cnt_r;
  logic             drain_r;
  line_addr_t       rd_ptr_r;
  line_addr_t       wr_ptr_r;
  logic [SAT_W-1:0] pos_r;
  logic [SAT_W-1:0] found_r;
  logic             pgood_r;
  logic [SAT_W-1:0] good_r;
  logic [FRAC_W-1:0] lo_r;
  logic [FRAC_W-1:0] hi_r;

  // Stage behind the line memory read, and the output register.
  logic             stg_v_r;
  logic             stg_mem_r;
  logic             stg_mask_r;
  logic             stg_keep_r;
  logic [SAT_W-1:0] stg_trim_r;
  logic [SAT_W-1:0] stg_found_r;
  logic             stg_eor_r;
  logic             out_v_r;
  base_t            out_base_r;
  logic             out_hb_r;
  logic             out_keep_r;
  logic [SAT_W-1:0] out_trim_r;
  logic [SAT_W-1:0] out_found_r;
  logic             out_eor_r;

  logic [5:0]        eff_k;
  logic [FILL_W-1:0] kmin1;
  logic              is_mask;
  logic              stg_move;
  logic              pipe_can;
  logic              pop_pend;
  logic              pop;
  logic              pop_emit;
  logic              flush_last;
  logic [FILL_W-1:0] fill_ai;
  logic [FILL_W-1:0] mask_ai;
  logic [FILL_W-1:0] fill_acc;
  logic              acc;
  base_t             in_base;
  logic [CNT_W-1:0]  in_cnt;
  logic              kmer_ok;
  logic              bad;
  logic              fin_load;
  logic              fin_keep;
  logic [SAT_W-1:0]  fin_trim;
  logic [SAT_W:0]    trim_sum;
  logic [SAT_W-1:0]  nk;
  logic              clear;
  base_t             rd_data;
  base_t             stg_base;

  assign in_base = in_tdata[7:0];
  assign in_cnt  = in_tdata[39:8];

  // Effective k: zero acts as one, anything above the line depth as the depth.
  always_comb begin
    if (klen_r == 6'd0) begin
      eff_k = 6'd1;
    end else if (klen_r > 6'(MAX_KMER)) begin
      eff_k = 6'(MAX_KMER);
    end else begin
      eff_k = klen_r;
    end
  end
  assign kmin1 = FILL_W'(eff_k - 6'd1);

  assign is_mask  = (mode_r == MODE_MASK);
  assign stg_move = stg_v_r && (!out_v_r || out_tready);
  assign pipe_can = !stg_v_r || stg_move;

  // A pop is owed while the line holds more than k-1 bases after a base was
  // taken, or while the mask mode drains the line after the last base. A
  // smaller k written between bases shortens the line only once the next
  // base is in.
  assign pop_pend = ((state_r == ST_RUN) && drain_r && (fill_r > kmin1)) ||
                    ((state_r == ST_FLUSH) && (fill_r != '0));
  assign pop        = pop_pend && (!is_mask || pipe_can);
  assign pop_emit   = pop && is_mask;
  assign flush_last = (state_r == ST_FLUSH) && (fill_r == FILL_W'(1));

  // Masked entries always form the oldest part of the line, so one count of
  // them replaces a mask bit per entry.
  assign fill_ai  = fill_r - FILL_W'(pop);
  assign mask_ai  = (pop && (mask_cnt_r != '0)) ? mask_cnt_r - FILL_W'(1) : mask_cnt_r;
  assign fill_acc = fill_ai + FILL_W'(1);

  assign in_tready = (state_r == ST_RUN) && (!drain_r || (fill_ai <= kmin1));
  assign acc       = in_tvalid && in_tready;
  assign kmer_ok   = (fill_ai >= kmin1);
  assign bad       = kmer_ok && (in_cnt < min_cnt_r);

  // Verdict for the non-mask modes.
  assign nk       = (pos_r >= SAT_W'(eff_k)) ? pos_r - SAT_W'(eff_k) + SAT_W'(1) : '0;
  assign trim_sum = (SAT_W+1)'(eff_k) + (SAT_W+1)'(good_r) - (SAT_W+1)'(1);
  assign fin_load = (state_r == ST_VERDICT) && pipe_can;

  always_comb begin
    fin_keep = 1'b0;
    fin_trim = '0;
    unique case (mode_r)
      MODE_COUNT: begin
        fin_keep = (CNT_W'(found_r) >= min_cnt_r) && (CNT_W'(found_r) <= max_cnt_r);
      end
      MODE_FRAC: begin
        fin_keep = (FRAC_W'(found_r) >= lo_r) && (FRAC_W'(found_r) <= hi_r);
      end
      MODE_TRIM: begin
        if (good_r != '0) begin
          fin_keep = 1'b1;
          fin_trim = trim_sum[SAT_W] ? SAT16 : trim_sum[SAT_W-1:0];
        end
      end
      default: begin
        fin_keep = 1'b0;
      end
    endcase
  end

  assign clear = fin_load || (pop && flush_last) ||
                 ((state_r == ST_FLUSH) && (fill_r == '0));

  // Configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_COUNT;
      klen_r     <= 6'd25;
      min_cnt_r  <= 32'd2;
      max_cnt_r  <= 32'hFFFF_FFFF;
      min_frac_r <= '0;
      max_frac_r <= 17'h10000;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MODE:     mode_r     <= cfg_wdata[1:0];
        CFG_KLEN:     klen_r     <= cfg_wdata[5:0];
        CFG_MIN_CNT:  min_cnt_r  <= cfg_wdata;
        CFG_MAX_CNT:  max_cnt_r  <= cfg_wdata;
        CFG_MIN_FRAC: min_frac_r <= cfg_wdata[FRAC_W-1:0];
        CFG_MAX_FRAC: max_frac_r <= cfg_wdata[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and read state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_RUN;
      fill_r     <= '0;
      mask_cnt_r <= '0;
      drain_r    <= 1'b0;
      rd_ptr_r   <= '0;
      wr_ptr_r   <= '0;
      pos_r      <= '0;
      found_r    <= '0;
      pgood_r    <= 1'b1;
      good_r     <= '0;
    end else if (clear) begin
      state_r    <= ST_RUN;
      fill_r     <= '0;
      mask_cnt_r <= '0;
      drain_r    <= 1'b0;
      rd_ptr_r   <= '0;
      wr_ptr_r   <= '0;
      pos_r      <= '0;
      found_r    <= '0;
      pgood_r    <= 1'b1;
      good_r     <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_r + LINE_AW'(pop);
      if (acc) begin
        fill_r     <= fill_acc;
        mask_cnt_r <= bad ? fill_acc : mask_ai;
        drain_r    <= 1'b1;
        wr_ptr_r   <= wr_ptr_r + LINE_AW'(1);
        if (pos_r != MAX_READ_LEN) begin
          pos_r <= pos_r + SAT_W'(1);
        end
        if (kmer_ok) begin
          if ((in_cnt != '0) && (found_r != SAT16)) begin
            found_r <= found_r + SAT_W'(1);
          end
          if (pgood_r && !bad) begin
            if (good_r != SAT16) begin
              good_r <= good_r + SAT_W'(1);
            end
          end else begin
            pgood_r <= 1'b0;
          end
        end
        if (in_tlast) begin
          state_r <= is_mask ? ST_FLUSH : ST_CALC;
        end
      end else begin
        fill_r     <= fill_ai;
        mask_cnt_r <= mask_ai;
        if (fill_ai <= kmin1) begin
          drain_r <= 1'b0;
        end
        if (state_r == ST_CALC) begin
          state_r <= ST_VERDICT;
        end
      end
    end
  end

  // Fraction limits, floor(fraction * nk / 2^16).
  always_ff @(posedge clk) begin
    if (state_r == ST_CALC) begin
      lo_r <= FRAC_W'(((FRAC_W+SAT_W)'(min_frac_r) * (FRAC_W+SAT_W)'(nk)) >> SAT_W);
      hi_r <= FRAC_W'(((FRAC_W+SAT_W)'(max_frac_r) * (FRAC_W+SAT_W)'(nk)) >> SAT_W);
    end
  end

  kcrf_line_ram u_line (
    .clk     (clk),
    .wr_en   (acc),
    .wr_addr (wr_ptr_r),
    .wr_data (in_base),
    .rd_en   (pop_emit),
    .rd_addr (rd_ptr_r),
    .rd_data (rd_data)
  );

  // Stage that lines up with the memory read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (pop_emit || fin_load) begin
      stg_v_r <= 1'b1;
    end else if (stg_move) begin
      stg_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_emit) begin
      stg_mem_r   <= 1'b1;
      stg_mask_r  <= (mask_cnt_r != '0);
      stg_keep_r  <= flush_last;
      stg_trim_r  <= '0;
      stg_found_r <= found_r;
      stg_eor_r   <= flush_last;
    end else if (fin_load) begin
      stg_mem_r   <= 1'b0;
      stg_mask_r  <= 1'b0;
      stg_keep_r  <= fin_keep;
      stg_trim_r  <= fin_trim;
      stg_found_r <= found_r;
      stg_eor_r   <= 1'b1;
    end
  end

  assign stg_base = stg_mem_r ? (stg_mask_r ? N_CHAR : rd_data) : 8'd0;

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (stg_move) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_move) begin
      out_base_r  <= stg_base;
      out_hb_r    <= stg_mem_r;
      out_keep_r  <= stg_keep_r;
      out_trim_r  <= stg_trim_r;
      out_found_r <= stg_found_r;
      out_eor_r   <= stg_eor_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, out_found_r, out_trim_r, out_keep_r, out_base_r};
  assign out_tuser  = out_hb_r;
  assign out_tlast  = out_eor_r;

  // The line never holds more bases than its depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(MAX_KMER))
    else $error("delay line overfilled");

  // Masked entries are a part of the line, never more than it holds.
  a_mask_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mask_cnt_r <= fill_r)
    else $error("mask count exceeds line fill");

  // A held stage entry is never overwritten by a new pop or verdict.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_v_r && !stg_move) |-> !(pop_emit || fin_load))
    else $error("stage overwritten while stalled");

  // The last base always starts the end-of-read work.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> (state_r == ST_FLUSH || state_r == ST_CALC))
    else $error("last base did not start end of read");

endmodule

@@ tb/kmer_count_read_filter_unit_tb.sv @@
// Self-checking testbench for kmer_count_read_filter_unit: a directed table, a
// receiver hold-off and random reads checked by a predictor.
// Depends on kcrf_pkg and the RTL of the block.
module kmer_count_read_filter_unit_tb;
  import kcrf_pkg::*;

  localparam int LIMIT       = 100_000;
  localparam int SETTLE      = 12;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [7:0]  obase;
    logic        has;
    logic        keep;
    logic [15:0] trim;
    logic [15:0] found;
    logic        eor;
  } read_out_t;

  typedef struct packed {
    logic        is_cfg;
    logic [2:0]  addr;
    logic [31:0] wdata;
    logic [7:0]  b;
    logic [31:0] cnt;
    logic        last;
    logic        typed;
    read_out_t   res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  kmer_count_read_filter_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  read_out_t   due_items[$];
  row_t        opening_rows[$];
  int          mismatches = 0;
  int unsigned cycles = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  // Register copies and read state of the predictor.
  logic [1:0]  set_mode;
  logic [5:0]  set_klen;
  logic [31:0] set_min_cnt;
  logic [31:0] set_max_cnt;
  logic [16:0] set_min_frac;
  logic [16:0] set_max_frac;
  logic [7:0]  rd_base [0:MAX_KMER-1];
  logic        rd_nmask [0:MAX_KMER-1];
  int unsigned rd_fill;
  int unsigned rd_pos;
  int unsigned rd_found;
  int unsigned rd_prefix_kmers;
  logic        rd_prefix_ok;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int unsigned eff_k();
    if (set_klen == 0) return 1;
    if (set_klen > MAX_KMER) return MAX_KMER;
    return set_klen;
  endfunction

  function automatic void clear_read();
    for (int i = 0; i < MAX_KMER; i++) begin
      rd_base[i] = '0;
      rd_nmask[i] = 1'b0;
    end
    rd_fill = 0;
    rd_pos = 0;
    rd_found = 0;
    rd_prefix_ok = 1'b1;
    rd_prefix_kmers = 0;
  endfunction

  // Drops the oldest base of the delay line; only mask mode turns it into an item.
  function automatic int line_pop();
    logic [7:0] ob;
    read_out_t  r;
    ob = rd_nmask[0] ? N_CHAR : rd_base[0];
    for (int i = 0; i + 1 < rd_fill; i++) begin
      rd_base[i] = rd_base[i+1];
      rd_nmask[i] = rd_nmask[i+1];
    end
    rd_fill--;
    rd_base[rd_fill] = '0;
    rd_nmask[rd_fill] = 1'b0;
    if (set_mode == MODE_MASK) begin
      r = {ob, 1'b1, 1'b0, 16'd0, rd_found[15:0], 1'b0};
      due_items.push_back(r);
      return 1;
    end
    return 0;
  endfunction

  function automatic void filter_base(input logic [7:0] b, input logic [31:0] cnt,
                                      input logic last);
    int unsigned k;
    int unsigned t;
    int          n;
    logic        bad;
    logic        keep;
    logic [15:0] trim;
    logic [63:0] nk;
    logic [63:0] lo;
    logic [63:0] hi;
    read_out_t   r;
    k = eff_k();
    n = 0;
    bad = 1'b0;
    if (rd_pos < 65535) rd_pos++;
    // A k-mer ends here once k-1 bases sit in the line.
    if (rd_fill + 1 >= k) begin
      if (cnt != 0 && rd_found < 65535) rd_found++;
      bad = cnt < set_min_cnt;
      if (rd_prefix_ok && !bad) begin
        if (rd_prefix_kmers < 65535) rd_prefix_kmers++;
      end else begin
        rd_prefix_ok = 1'b0;
      end
      if (bad) begin
        for (int i = 0; i < rd_fill; i++) rd_nmask[i] = 1'b1;
      end
    end
    if (rd_fill < MAX_KMER) begin
      rd_base[rd_fill] = b;
      rd_nmask[rd_fill] = bad;
      rd_fill++;
    end
    while (rd_fill > k - 1) n += line_pop();
    if (last) begin
      if (set_mode == MODE_MASK) begin
        while (rd_fill > 0) n += line_pop();
        if (n > 0) begin
          r = due_items.pop_back();
          r.keep = 1'b1;
          r.eor = 1'b1;
          due_items.push_back(r);
        end
      end else begin
        keep = 1'b0;
        trim = '0;
        case (set_mode)
          MODE_COUNT: begin
            keep = (rd_found >= set_min_cnt) && (rd_found <= set_max_cnt);
          end
          MODE_FRAC: begin
            nk = (rd_pos >= k) ? {32'd0, rd_pos - k + 1} : 64'd0;
            lo = ({47'd0, set_min_frac} * nk) >> 16;
            hi = ({47'd0, set_max_frac} * nk) >> 16;
            keep = ({32'd0, rd_found} >= lo) && ({32'd0, rd_found} <= hi);
          end
          default: begin
            if (rd_prefix_kmers > 0) begin
              keep = 1'b1;
              t = k + rd_prefix_kmers - 1;
              trim = (t > 65535) ? 16'hFFFF : t[15:0];
            end
          end
        endcase
        r = {8'd0, 1'b0, keep, trim, rd_found[15:0], 1'b1};
        due_items.push_back(r);
      end
      clear_read();
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    read_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_items.size() == 0) begin
        $error("item on out_* with nothing due: tdata %h", out_tdata);
        mismatches++;
      end else begin
        want = due_items.pop_front();
        check_field("out_base", want.obase, out_tdata[7:0]);
        check_field("has_base", want.has, out_tuser);
        check_field("keep", want.keep, out_tdata[8]);
        check_field("trim_length", want.trim, out_tdata[24:9]);
        check_field("kmers_found", want.found, out_tdata[40:25]);
        check_field("end_of_read", want.eor, out_tlast);
      end
    end
  end

  // Receiver: random stalls, or a long hold-off counted here once requested.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    case (idx)
      CFG_MODE:     set_mode = v[1:0];
      CFG_KLEN:     set_klen = v[5:0];
      CFG_MIN_CNT:  set_min_cnt = v;
      CFG_MAX_CNT:  set_max_cnt = v;
      CFG_MIN_FRAC: set_min_frac = v[16:0];
      CFG_MAX_FRAC: set_max_frac = v[16:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_item(input logic [7:0] b, input logic [31:0] cnt, input logic last);
    cfg_we <= 1'b0;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {cnt, b};
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    filter_base(b, cnt, last);
  endtask

  // Stops offering bases until every due item is back and the block has settled.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    cfg_we <= 1'b0;
    @(posedge clk);
    while (due_items.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_base();
    case ($urandom_range(4))
      0: return "A";
      1: return "C";
      2: return "G";
      3: return "T";
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [31:0] pick_count();
    case ($urandom_range(7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      3: return set_min_cnt;
      4: return set_min_cnt - 1;
      default: return $urandom_range(1, 5);
    endcase
  endfunction

  task automatic pick_settings(input logic [1:0] mode);
    logic [31:0] k;
    logic [31:0] lo_c;
    logic [31:0] hi_c;
    logic [31:0] lo_f;
    logic [31:0] hi_f;
    case ($urandom_range(7))
      0: k = 0;
      1: k = MAX_KMER;
      2: k = $urandom_range(33, 63);
      default: k = $urandom_range(1, 6);
    endcase
    case ($urandom_range(5))
      0: lo_c = 32'd0;
      1: lo_c = 32'hFFFF_FFFF;
      default: lo_c = $urandom_range(1, 4);
    endcase
    case ($urandom_range(5))
      0: hi_c = 32'd0;
      1: hi_c = 32'hFFFF_FFFF;
      default: hi_c = $urandom_range(0, 12);
    endcase
    case ($urandom_range(5))
      0: lo_f = 32'd0;
      1: lo_f = 32'd65536;
      2: lo_f = 32'h1FFFF;
      default: lo_f = $urandom_range(0, 65536);
    endcase
    case ($urandom_range(5))
      0: hi_f = 32'd0;
      1: hi_f = 32'd65536;
      2: hi_f = 32'h1FFFF;
      default: hi_f = $urandom_range(0, 65536);
    endcase
    write_reg(CFG_MODE, {30'd0, mode});
    write_reg(CFG_KLEN, k);
    write_reg(CFG_MIN_CNT, lo_c);
    write_reg(CFG_MAX_CNT, hi_c);
    write_reg(CFG_MIN_FRAC, lo_f);
    write_reg(CFG_MAX_FRAC, hi_f);
  endtask

  function automatic void add_cfg(input logic [2:0] idx, input logic [31:0] v);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.addr = idx;
    r.wdata = v;
    opening_rows.push_back(r);
  endfunction

  function automatic void add_base(input logic [7:0] b, input logic [31:0] cnt,
                                   input logic last);
    row_t r;
    r = '0;
    r.b = b;
    r.cnt = cnt;
    r.last = last;
    opening_rows.push_back(r);
  endfunction

  // A last base whose single item is known up front.
  function automatic void add_known(input logic [7:0] b, input logic [31:0] cnt,
                                    input logic [7:0] ob, input logic hb, input logic keep,
                                    input logic [15:0] trim, input logic [15:0] found);
    row_t r;
    r = '0;
    r.b = b;
    r.cnt = cnt;
    r.last = 1'b1;
    r.typed = 1'b1;
    r.res = {ob, hb, keep, trim, found, 1'b1};
    opening_rows.push_back(r);
  endfunction

  initial begin : stimulus
    logic prev_cfg;
    int   sent;
    int   len;
    int   k;
    set_mode = MODE_COUNT;
    set_klen = 6'd25;
    set_min_cnt = 32'd2;
    set_max_cnt = 32'hFFFF_FFFF;
    set_min_frac = 17'd0;
    set_max_frac = 17'd65536;
    clear_read();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    // Short read under the reset settings: no k-mer, so the total is zero.
    add_known("A", 32'd0, 8'd0, 1'b0, 1'b0, 16'd0, 16'd0);
    add_cfg(CFG_KLEN, 32'd1);
    add_cfg(CFG_MIN_CNT, 32'd0);
    add_known(8'hFF, 32'hFFFF_FFFF, 8'd0, 1'b0, 1'b1, 16'd0, 16'd1);
    // A k of zero behaves as one.
    add_cfg(CFG_KLEN, 32'd0);
    add_cfg(CFG_MAX_CNT, 32'd0);
    add_known(8'h00, 32'd0, 8'd0, 1'b0, 1'b1, 16'd0, 16'd0);
    add_known("C", 32'd9, 8'd0, 1'b0, 1'b0, 16'd0, 16'd1);
    add_cfg(CFG_MODE, {30'd0, MODE_FRAC});
    add_cfg(CFG_MIN_FRAC, 32'd65536);
    add_cfg(CFG_MAX_FRAC, 32'd65536);
    add_base("G", 32'd0, 1'b0);
    add_known("T", 32'd5, 8'd0, 1'b0, 1'b0, 16'd0, 16'd1);
    add_cfg(CFG_MODE, {30'd0, MODE_TRIM});
    add_cfg(CFG_KLEN, 32'd2);
    add_cfg(CFG_MIN_CNT, 32'hFFFF_FFFF);
    add_base("A", 32'd3, 1'b0);
    add_known("C", 32'hFFFF_FFFF, 8'd0, 1'b0, 1'b1, 16'd2, 16'd1);
    // Short read in trim mode is rejected.
    add_known("G", 32'd7, 8'd0, 1'b0, 1'b0, 16'd0, 16'd0);
    add_cfg(CFG_MODE, {30'd0, MODE_MASK});
    add_cfg(CFG_KLEN, 32'd3);
    add_cfg(CFG_MIN_CNT, 32'd2);
    add_cfg(CFG_MAX_CNT, 32'hFFFF_FFFF);
    add_base("A", 32'd5, 1'b0);
    add_base("C", 32'd9, 1'b0);
    add_base("G", 32'd1, 1'b0);
    add_base("T", 32'd4, 1'b0);
    add_base("A", 32'd3, 1'b0);
    add_base("C", 32'd0, 1'b1);
    // Short read in mask mode passes its base through.
    add_known("X", 32'd0, "X", 1'b1, 1'b1, 16'd0, 16'd0);
    // Shrinking k in the middle of a read drains the line.
    add_cfg(CFG_KLEN, 32'd5);
    add_base("A", 32'd3, 1'b0);
    add_base("C", 32'd3, 1'b0);
    add_base("G", 32'd3, 1'b0);
    add_base("T", 32'd3, 1'b0);
    add_cfg(CFG_KLEN, 32'd2);
    add_base("A", 32'd0, 1'b1);
    // Leaving mask mode in the middle of a read: the verdict follows the new mode.
    add_base("G", 32'd2, 1'b0);
    add_base("G", 32'd2, 1'b0);
    add_cfg(CFG_MODE, {30'd0, MODE_COUNT});
    add_base("T", 32'd1, 1'b1);

    prev_cfg = 1'b1;
    foreach (opening_rows[i]) begin
      if (opening_rows[i].is_cfg) begin
        if (!prev_cfg) wait_idle();
        write_reg(opening_rows[i].addr, opening_rows[i].wdata);
      end else begin
        send_item(opening_rows[i].b, opening_rows[i].cnt, opening_rows[i].last);
        if (opening_rows[i].typed) begin
          void'(due_items.pop_back());
          due_items.push_back(opening_rows[i].res);
        end
      end
      prev_cfg = opening_rows[i].is_cfg;
    end

    // Receiver holds off while a mask read streams in, so the block backs up.
    wait_idle();
    write_reg(CFG_MODE, {30'd0, MODE_MASK});
    write_reg(CFG_KLEN, 32'd8);
    write_reg(CFG_MIN_CNT, 32'd2);
    hold_req++;
    for (int i = 0; i < 40; i++) send_item(pick_base(), pick_count(), i == 39);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 66; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 66; end
        default: begin tx_idle_pct = 7; rx_stall_pct = 7; end
      endcase
      for (int s = 0; s < 3; s++) begin
        wait_idle();
        pick_settings((p * 3 + s) % 4);
        k = eff_k();
        sent = 0;
        while (sent < 8) begin
          len = ($urandom_range(3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, k + 4);
          for (int i = 0; i < len; i++) send_item(pick_base(), pick_count(), i == len - 1);
          sent += len;
        end
      end
    end

    in_tvalid <= 1'b0;
    cfg_we <= 1'b0;
    for (int w = 0; w < 20000 && due_items.size() != 0; w++) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (due_items.size() != 0) begin
      $error("%0d items still due at the end", due_items.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
